[design/litc_pkg.sv]
// Package for the linear index to coordinates block: widths, register codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package litc_pkg;
    localparam int DEF_MAX_RANK    = 4;
    localparam int DEF_INDEX_WIDTH = 32;
    localparam int AXIS_REGS       = 4;
    localparam int SIZE_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int AXIS_W          = 2;
    localparam int RANK_W          = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS3 = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [AXIS_W-1:0] axis;
        logic [SIZE_W-1:0] coord;
        logic              last;
    } t_result;
endpackage

[design/litc_front.sv]
// Front end: config registers, input acceptance, queue of pending indexes.
// Depends on litc_pkg.
`timescale 1ns / 1ps
module litc_front import litc_pkg::*; #(
    parameter int MAX_RANK    = DEF_MAX_RANK,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [INDEX_WIDTH-1:0] i_index,
    output logic                   o_q_valid,
    input  logic                   i_q_pop,
    output logic [INDEX_WIDTH-1:0] o_q_index,
    output logic [RANK_W-1:0]      o_rank,
    output logic [SIZE_W-1:0]      o_size [AXIS_REGS]
);
    localparam int LIM = (MAX_RANK < AXIS_REGS) ? MAX_RANK : AXIS_REGS;
    logic [RANK_W-1:0]      r_rank;
    logic [SIZE_W-1:0]      r_size [AXIS_REGS];
    logic [INDEX_WIDTH-1:0] r_q [2];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;
    logic                   push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= 3'd4;
            for (int i = 0; i < AXIS_REGS; i++) r_size[i] <= SIZE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RANK: r_rank <= i_cfg_data[RANK_W-1:0];
                REG_AXIS0, REG_AXIS1, REG_AXIS2, REG_AXIS3: begin
                    if (i_cfg_data != '0) r_size[2'(i_cfg_idx - 3'd1)] <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_rank = r_rank;
        if (r_rank == '0) o_rank = 3'd1;
        if (r_rank > RANK_W'(LIM)) o_rank = RANK_W'(LIM);
    end
    assign o_size = r_size;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_index = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_index;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

[design/litc_div.sv]
// Radix-2 restoring divider: running value by axis size, one quotient bit per cycle.
// Depends on litc_pkg.
`timescale 1ns / 1ps
module litc_div import litc_pkg::*; #(
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [INDEX_WIDTH-1:0] i_num,
    input  logic [SIZE_W-1:0]      i_den,
    output logic                   o_done,
    output logic [INDEX_WIDTH-1:0] o_quot,
    output logic [SIZE_W-1:0]      o_rem
);
    localparam int CW = $clog2(INDEX_WIDTH + 1);
    logic [INDEX_WIDTH-1:0] r_q;
    logic [SIZE_W-1:0]      r_r;
    logic [SIZE_W-1:0]      r_d;
    logic [CW-1:0]          r_n;
    logic                   r_busy;
    logic [SIZE_W:0]        sh;

    assign sh = {r_r, r_q[INDEX_WIDTH-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0; r_n <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_n <= CW'(INDEX_WIDTH);
            end else if (r_busy) begin
                r_n <= r_n - CW'(1);
                if (r_n == CW'(1)) begin
                    r_busy <= 1'b0; o_done <= 1'b1;
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num; r_r <= '0; r_d <= i_den;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_d}) begin
                r_r <= SIZE_W'(sh - {1'b0, r_d});
                r_q <= {r_q[INDEX_WIDTH-2:0], 1'b1};
            end else begin
                r_r <= sh[SIZE_W-1:0];
                r_q <= {r_q[INDEX_WIDTH-2:0], 1'b0};
            end
        end
    end
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

[design/litc_back.sv]
// Back end: walks the axes innermost first, drives the divider, holds each result in an output register.
// Depends on litc_pkg and litc_div.
`timescale 1ns / 1ps
module litc_back import litc_pkg::*; #(
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  logic [INDEX_WIDTH-1:0] i_q_index,
    input  logic [RANK_W-1:0]      i_rank,
    input  logic [SIZE_W-1:0]      i_size [AXIS_REGS],
    output t_result                o_res,
    input  logic                   i_res_ready
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_DIV = 4'b0010, S_OUT = 4'b0100, S_NEXT = 4'b1000
    } t_state;
    t_state                 r_state;
    logic [INDEX_WIDTH-1:0] r_run;
    logic [AXIS_W-1:0]      r_axis;
    logic                   start, done;
    logic [INDEX_WIDTH-1:0] quot;
    logic [SIZE_W-1:0]      rem;
    logic                   out_free;

    assign out_free = !o_res.valid || i_res_ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign start    = o_q_pop || (r_state == S_NEXT);

    litc_div #(.INDEX_WIDTH(INDEX_WIDTH)) u_div (
        .i_clk, .i_rst_n, .i_start(start),
        .i_num(o_q_pop ? i_q_index : r_run),
        .i_den(i_size[o_q_pop ? 2'(i_rank - 3'd1) : r_axis]),
        .o_done(done), .o_quot(quot), .o_rem(rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; o_res.valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) o_res.valid <= 1'b1;
            else if (i_res_ready) o_res.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_q_valid) r_state <= S_DIV;
                S_DIV:  if (done) r_state <= S_OUT;
                S_OUT:  if (out_free) r_state <= (r_axis == '0) ? S_IDLE : S_NEXT;
                S_NEXT: r_state <= S_DIV;
                default: r_state <= S_IDLE;
            endcase
            if (o_q_pop) r_axis <= 2'(i_rank - 3'd1);
            if (r_state == S_OUT && out_free) begin
                o_res.axis  <= r_axis;
                o_res.coord <= rem;
                o_res.last  <= (r_axis == '0);
                r_run       <= quot;
                r_axis      <= r_axis - 2'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == S_IDLE) else $error("pop outside idle");
    a_done_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> r_state == S_DIV) else $error("divider done out of step");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !i_res_ready |=> o_res.valid && $stable(o_res.coord))
        else $error("result word dropped");
`endif
endmodule

[design/linear_index_to_coordinates_top.sv]
// Top level: flat index to per-axis coordinates.
// Depends on litc_pkg, litc_front, litc_back.
//  channel | dir | fields
//  s_axis  | in  | tdata[INDEX_WIDTH-1:0] flat_index
//  m_axis  | out | tdata[1:0] axis, [17:2] coordinate; tlast last
//  cfg     | in  | we, idx, data
// Each axis is resolved by one division in the bit-serial divider.
// A two-entry queue holds incoming indexes while the back end works.
// Reset is synchronous, active low; rank 4, sizes 1.
`timescale 1ns / 1ps
module linear_index_to_coordinates_top import litc_pkg::*; #(
    parameter int MAX_RANK    = DEF_MAX_RANK,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]            i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [((INDEX_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // flat_index
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // axis, coordinate
    output logic                             m_axis_tlast
);
    logic                   q_valid, q_pop;
    logic [INDEX_WIDTH-1:0] q_index;
    logic [RANK_W-1:0]      rank;
    logic [SIZE_W-1:0]      size [AXIS_REGS];
    t_result                res;

    litc_front #(.MAX_RANK(MAX_RANK), .INDEX_WIDTH(INDEX_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_index(s_axis_tdata[INDEX_WIDTH-1:0]),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_index(q_index),
        .o_rank(rank), .o_size(size)
    );
    litc_back #(.INDEX_WIDTH(INDEX_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_index(q_index),
        .i_rank(rank), .i_size(size), .o_res(res), .i_res_ready(m_axis_tready)
    );
    assign m_axis_tvalid = res.valid;
    assign m_axis_tdata  = {6'd0, res.coord, res.axis};
    assign m_axis_tlast  = res.last;
endmodule
